// ===== design/cpmd_pkg.sv =====
// shared types, constants and helpers for the convex polygon distance block
package cpmd_pkg;

	localparam int MAX_VERTS = 1024;
	localparam int IDX_W     = $clog2(MAX_VERTS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int ACC_W     = 50;
	localparam int DIST_W    = 25;
	localparam int REM_W     = 28;
	localparam int ITER_W    = 6;

	localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
	localparam logic [ITER_W-1:0] ITER_SQRT  = ITER_W'(ACC_W / 2);
	localparam logic [ITER_W-1:0] ITER_DIV   = ITER_W'(ACC_W);
	localparam logic [CNT_W-1:0]  MIN_VERTS  = CNT_W'(3);

	// request codes on the input tuser
	localparam logic [1:0] REQ_LOAD_A  = 2'd0;
	localparam logic [1:0] REQ_LOAD_B  = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
	} vtx_t;

	typedef struct packed {
		logic signed [24:0] x;
		logic signed [24:0] y;
	} dvec_t;

	// multiply-accumulate request and response
	typedef struct packed {
		logic  start;
		logic  dot;
		dvec_t u;
		dvec_t v;
	} mac_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W-1:0] acc;
	} mac_rsp_t;

	// root / divide request and response
	typedef struct packed {
		logic               start;
		logic               is_div;
		logic [ACC_W-1:0]   src;
		logic [DIST_W-1:0]  den;
	} rdv_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] res;
	} rdv_rsp_t;

	// vertex store read request
	typedef struct packed {
		logic             en;
		logic             poly_b;
		logic [IDX_W-1:0] idx;
	} vrd_req_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_MUL1,
		MP_MUL2,
		MP_ACC
	} mph_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_OR_RD,
		ST_OR_WT,
		ST_OR_GO,
		ST_OR_CHK,
		ST_SC_RD,
		ST_SC_WT,
		ST_FT_RD,
		ST_FT_WT,
		ST_AR_GO,
		ST_AR_CHK,
		ST_LN_GO,
		ST_LN_WT,
		ST_I1_GO,
		ST_I1_WT,
		ST_I2_GO,
		ST_I2_WT,
		ST_RT_GO,
		ST_RT_WT,
		ST_CX_GO,
		ST_CX_WT,
		ST_DV_GO,
		ST_DV_WT,
		ST_PD_GO,
		ST_PD_WT,
		ST_PR_GO,
		ST_PR_WT,
		ST_SP_END,
		ST_DONE
	} st_t;

	function automatic dvec_t vsub(vtx_t p, vtx_t q);
		dvec_t d;
		d.x = {p.x[23], p.x} - {q.x[23], q.x};
		d.y = {p.y[23], p.y} - {q.y[23], q.y};
		return d;
	endfunction

	function automatic logic [ACC_W-1:0] mag(logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
	endfunction

	function automatic logic [DIST_W-1:0] dsat(logic [ACC_W-1:0] v);
		return (v > ACC_W'(DIST_MAX)) ? DIST_MAX : v[DIST_W-1:0];
	endfunction

endpackage

// ===== design/convex_polygon_min_distance.sv =====
// Minimum distance between two convex polygons by rotating calipers.
//
// Input stream (s_*): each transaction carries a request kind in s_tuser and
// a vertex in s_tdata. Kind load A / load B appends the vertex to that polygon
// (ignored once a polygon holds 1024 vertices). Kind compute runs the caliper
// walk and produces one output transaction; the vertex data is then unused.
// Any other kind is taken and dropped.
// Output stream (m_*): min_distance in m_tdata (unsigned integer, no fraction
// bits), result_valid in m_tuser; result_valid is 0 with distance 0 when either
// polygon has fewer than three vertices. Both counts clear after a compute.
// Work of a compute: per polygon the turn of the first vertex triple, one
// more turn per further collinear triple and a read of every vertex for the
// extreme vertex search; then per edge of A a fetch of the caliper vertices,
// a cross product per caliper check, another fetch per caliper advance and one
// distance evaluation, four of those when the edges are parallel; the result
// is then presented. The cost is set by the single shared multiplier and the
// bit-serial root and divide unit (25 and 50 iterations). s_tready is high
// only while idle. A stalled output holds its transaction; a finished compute
// then waits before clearing. Reset empties both polygons and drops any output.
module convex_polygon_min_distance import cpmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // coord_x [23:0], coord_y [47:24]
	input  logic [1:0]  s_tuser,   // req_type [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // min_distance [24:0], zero fill [31:25]
	output logic [0:0]  m_tuser    // result_valid [0]
);

	st_t st_q, st_nxt;

	mac_req_t mac_req;
	mac_rsp_t mac_rsp;
	rdv_req_t rdv_req;
	rdv_rsp_t rdv_rsp;
	vrd_req_t vrd;
	vtx_t     rd_v, in_v;

	logic [CNT_W-1:0]  cnt_a, cnt_b, cur_cnt;
	logic              in_acc, out_free, wr_en, clear;
	logic              poly_q, rev_a_q, rev_b_q;
	logic [CNT_W-1:0]  k_q, steps_q;
	logic [IDX_W-1:0]  ext_idx_q, ia_q, jb_q, e_q, ia1, jb1, sel_idx;
	logic signed [23:0] ext_y_q;
	vtx_t              w0_q, w1_q, w2_q, a0_q, a1_q, b0_q, b1_q, pa, pb, pc;
	logic [1:0]        f_q, sp_k_q;
	logic              par_q, pd_sel_q, better, last_edge;
	logic [ACC_W-1:0]  len2_q;
	logic [DIST_W-1:0] l_q, cand_q, best_q, best_new, res_dist_q;
	logic              res_ok_q, m_valid_q;
	logic [DIST_W-1:0] m_dist_q;
	logic              m_ok_q;
	logic              acc_pos, acc_neg, acc_zero, few;

	assign in_v.x   = s_tdata[23:0];
	assign in_v.y   = s_tdata[47:24];
	assign s_tready = (st_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign wr_en    = in_acc && (s_tuser == REQ_LOAD_A || s_tuser == REQ_LOAD_B);
	assign clear    = (st_q == ST_DONE) && out_free;

	cpmd_vstore u_vstore (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_b   (s_tuser == REQ_LOAD_B),
		.wr_v   (in_v),
		.clear  (clear),
		.rd     (vrd),
		.rev_a  (rev_a_q),
		.rev_b  (rev_b_q),
		.cnt_a  (cnt_a),
		.cnt_b  (cnt_b),
		.rd_v   (rd_v)
	);

	cpmd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	cpmd_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rdv_req),
		.rsp    (rdv_rsp)
	);

	// common conditions
	always_comb begin
		cur_cnt   = poly_q ? cnt_b : cnt_a;
		few       = (cnt_a < MIN_VERTS) || (cnt_b < MIN_VERTS);
		acc_neg   = mac_rsp.acc[ACC_W-1];
		acc_zero  = (mac_rsp.acc == '0);
		acc_pos   = !acc_neg && !acc_zero;
		ia1       = ({1'b0, ia_q} + CNT_W'(1) == cnt_a) ? '0 : ia_q + IDX_W'(1);
		jb1       = ({1'b0, jb_q} + CNT_W'(1) == cnt_b) ? '0 : jb_q + IDX_W'(1);
		better    = (k_q == '0) ||
		            (poly_q ? (rd_v.y > ext_y_q) : (rd_v.y < ext_y_q));
		sel_idx   = better ? k_q[IDX_W-1:0] : ext_idx_q;
		best_new  = (cand_q < best_q) ? cand_q : best_q;
		last_edge = ({1'b0, e_q} == cnt_a - CNT_W'(1));
	end

	// segment endpoints and query point of the current distance evaluation
	always_comb begin
		case (sp_k_q)
			2'd0:    begin pa = a0_q; pb = a1_q; pc = b0_q; end
			2'd1:    begin pa = a0_q; pb = a1_q; pc = b1_q; end
			2'd2:    begin pa = b0_q; pb = b1_q; pc = a0_q; end
			default: begin pa = b0_q; pb = b1_q; pc = a1_q; end
		endcase
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_acc && s_tuser == REQ_COMPUTE) st_nxt = few ? ST_DONE : ST_OR_RD;
			end
			ST_OR_RD:  st_nxt = ST_OR_WT;
			ST_OR_WT:  st_nxt = (k_q >= CNT_W'(2)) ? ST_OR_GO : ST_OR_RD;
			ST_OR_GO:  st_nxt = ST_OR_CHK;
			ST_OR_CHK: begin
				if (mac_rsp.done) begin
					if (acc_zero && k_q < cur_cnt) st_nxt = ST_OR_RD;
					else                           st_nxt = poly_q ? ST_SC_RD : ST_OR_RD;
				end
			end
			ST_SC_RD:  st_nxt = ST_SC_WT;
			ST_SC_WT: begin
				if (k_q == cur_cnt - CNT_W'(1)) st_nxt = poly_q ? ST_FT_RD : ST_SC_RD;
				else                            st_nxt = ST_SC_RD;
			end
			ST_FT_RD:  st_nxt = ST_FT_WT;
			ST_FT_WT:  st_nxt = (f_q == 2'd3) ? ST_AR_GO : ST_FT_RD;
			ST_AR_GO:  st_nxt = ST_AR_CHK;
			ST_AR_CHK: begin
				if (mac_rsp.done) st_nxt = (acc_pos && steps_q < cnt_b) ? ST_FT_RD : ST_LN_GO;
			end
			ST_LN_GO:  st_nxt = ST_LN_WT;
			ST_LN_WT:  if (mac_rsp.done) st_nxt = acc_zero ? ST_PD_GO : ST_I1_GO;
			ST_I1_GO:  st_nxt = ST_I1_WT;
			ST_I1_WT:  if (mac_rsp.done) st_nxt = acc_neg ? ST_PD_GO : ST_I2_GO;
			ST_I2_GO:  st_nxt = ST_I2_WT;
			ST_I2_WT:  if (mac_rsp.done) st_nxt = acc_neg ? ST_PD_GO : ST_RT_GO;
			ST_RT_GO:  st_nxt = ST_RT_WT;
			ST_RT_WT:  if (rdv_rsp.done) st_nxt = ST_CX_GO;
			ST_CX_GO:  st_nxt = ST_CX_WT;
			ST_CX_WT:  if (mac_rsp.done) st_nxt = ST_DV_GO;
			ST_DV_GO:  st_nxt = ST_DV_WT;
			ST_DV_WT:  if (rdv_rsp.done) st_nxt = ST_SP_END;
			ST_PD_GO:  st_nxt = ST_PD_WT;
			ST_PD_WT:  if (mac_rsp.done) st_nxt = ST_PR_GO;
			ST_PR_GO:  st_nxt = ST_PR_WT;
			ST_PR_WT:  if (rdv_rsp.done) st_nxt = ST_SP_END;
			ST_SP_END: begin
				if (par_q && sp_k_q != 2'd3) st_nxt = ST_LN_GO;
				else                         st_nxt = last_edge ? ST_DONE : ST_FT_RD;
			end
			ST_DONE:   if (out_free) st_nxt = ST_IDLE;
			default:   st_nxt = ST_IDLE;
		endcase
	end

	// unit requests and memory reads
	always_comb begin
		mac_req        = '0;
		rdv_req        = '0;
		vrd            = '0;
		vrd.poly_b     = poly_q;
		vrd.idx        = k_q[IDX_W-1:0];
		case (st_q)
			ST_OR_RD, ST_SC_RD: vrd.en = 1'b1;
			ST_FT_RD: begin
				vrd.en     = 1'b1;
				vrd.poly_b = f_q[1];
				case (f_q)
					2'd0:    vrd.idx = ia_q;
					2'd1:    vrd.idx = ia1;
					2'd2:    vrd.idx = jb_q;
					default: vrd.idx = jb1;
				endcase
			end
			ST_OR_GO: begin
				mac_req.start = 1'b1;
				mac_req.u     = vsub(w1_q, w0_q);
				mac_req.v     = vsub(w2_q, w0_q);
			end
			ST_AR_GO: begin
				mac_req.start = 1'b1;
				mac_req.u     = vsub(b1_q, b0_q);
				mac_req.v     = vsub(a0_q, a1_q);
			end
			ST_LN_GO: begin
				mac_req.start = 1'b1;
				mac_req.dot   = 1'b1;
				mac_req.u     = vsub(pb, pa);
				mac_req.v     = vsub(pb, pa);
			end
			ST_I1_GO: begin
				mac_req.start = 1'b1;
				mac_req.dot   = 1'b1;
				mac_req.u     = vsub(pb, pa);
				mac_req.v     = vsub(pc, pa);
			end
			ST_I2_GO: begin
				mac_req.start = 1'b1;
				mac_req.dot   = 1'b1;
				mac_req.u     = vsub(pa, pb);
				mac_req.v     = vsub(pc, pb);
			end
			ST_CX_GO: begin
				mac_req.start = 1'b1;
				mac_req.u     = vsub(pb, pa);
				mac_req.v     = vsub(pc, pa);
			end
			ST_PD_GO: begin
				mac_req.start = 1'b1;
				mac_req.dot   = 1'b1;
				mac_req.u     = pd_sel_q ? vsub(pa, pc) : vsub(pb, pc);
				mac_req.v     = pd_sel_q ? vsub(pa, pc) : vsub(pb, pc);
			end
			ST_RT_GO: begin
				rdv_req.start = 1'b1;
				rdv_req.src   = len2_q;
			end
			ST_DV_GO: begin
				rdv_req.start  = 1'b1;
				rdv_req.is_div = 1'b1;
				rdv_req.src    = mag(mac_rsp.acc);
				rdv_req.den    = l_q;
			end
			ST_PR_GO: begin
				rdv_req.start = 1'b1;
				rdv_req.src   = mac_rsp.acc;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (clear)         m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				poly_q     <= 1'b0;
				k_q        <= '0;
				rev_a_q    <= 1'b0;
				rev_b_q    <= 1'b0;
				best_q     <= DIST_MAX;
				res_dist_q <= '0;
				res_ok_q   <= 1'b0;
			end
			ST_OR_WT: begin
				w0_q <= w1_q;
				w1_q <= w2_q;
				w2_q <= rd_v;
				k_q  <= k_q + CNT_W'(1);
			end
			ST_OR_CHK: begin
				if (mac_rsp.done && !(acc_zero && k_q < cur_cnt)) begin
					if (acc_neg) begin
						if (poly_q) rev_b_q <= 1'b1;
						else        rev_a_q <= 1'b1;
					end
					poly_q <= !poly_q;
					k_q    <= '0;
				end
			end
			ST_SC_WT: begin
				if (better) begin
					ext_idx_q <= k_q[IDX_W-1:0];
					ext_y_q   <= rd_v.y;
				end
				k_q <= k_q + CNT_W'(1);
				if (k_q == cur_cnt - CNT_W'(1)) begin
					if (poly_q) jb_q <= sel_idx;
					else        ia_q <= sel_idx;
					poly_q  <= 1'b1;
					k_q     <= '0;
					f_q     <= 2'd0;
					steps_q <= '0;
					e_q     <= '0;
				end
			end
			ST_FT_WT: begin
				case (f_q)
					2'd0:    a0_q <= rd_v;
					2'd1:    a1_q <= rd_v;
					2'd2:    b0_q <= rd_v;
					default: b1_q <= rd_v;
				endcase
				f_q <= f_q + 2'd1;
			end
			ST_AR_CHK: begin
				if (mac_rsp.done) begin
					if (acc_pos && steps_q < cnt_b) begin
						b0_q    <= b1_q;
						jb_q    <= jb1;
						steps_q <= steps_q + CNT_W'(1);
						f_q     <= 2'd3;
					end else begin
						par_q  <= acc_zero;
						sp_k_q <= 2'd0;
					end
				end
			end
			ST_LN_WT: begin
				len2_q   <= mac_rsp.acc;
				pd_sel_q <= 1'b0;
			end
			ST_I1_WT:  pd_sel_q <= 1'b1;
			ST_I2_WT:  pd_sel_q <= 1'b0;
			ST_RT_WT:  l_q      <= rdv_rsp.res[DIST_W-1:0];
			ST_DV_WT, ST_PR_WT: cand_q <= dsat(rdv_rsp.res);
			ST_SP_END: begin
				best_q <= best_new;
				if (par_q && sp_k_q != 2'd3) begin
					sp_k_q <= sp_k_q + 2'd1;
				end else begin
					ia_q       <= ia1;
					e_q        <= e_q + IDX_W'(1);
					f_q        <= 2'd0;
					steps_q    <= '0;
					res_dist_q <= best_new;
					res_ok_q   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (clear) begin
			m_dist_q <= res_dist_q;
			m_ok_q   <= res_ok_q;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {7'd0, m_dist_q};
	assign m_tuser[0] = m_ok_q;

endmodule

// ===== design/cpmd_vstore.sv =====
// vertex memories for both polygons, with vertex counts and reversed-order read
module cpmd_vstore import cpmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_b,
	input  vtx_t             wr_v,
	input  logic             clear,
	input  vrd_req_t         rd,
	input  logic             rev_a,
	input  logic             rev_b,
	output logic [CNT_W-1:0] cnt_a,
	output logic [CNT_W-1:0] cnt_b,
	output vtx_t             rd_v
);

	vtx_t mem_a [MAX_VERTS];
	vtx_t mem_b [MAX_VERTS];

	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic             wr_a_ok, wr_b_ok;
	logic [CNT_W-1:0] rpa, rpb;
	logic [IDX_W-1:0] addr_a, addr_b;
	vtx_t             ra_q, rb_q;
	logic             sel_q;

	assign wr_a_ok = wr_en && !wr_b && (cnt_a_q < CNT_W'(MAX_VERTS));
	assign wr_b_ok = wr_en &&  wr_b && (cnt_b_q < CNT_W'(MAX_VERTS));

	// counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
		end else if (clear) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
		end else begin
			if (wr_a_ok) cnt_a_q <= cnt_a_q + CNT_W'(1);
			if (wr_b_ok) cnt_b_q <= cnt_b_q + CNT_W'(1);
		end
	end

	// logical to physical index, mirrored when the polygon is reversed
	always_comb begin
		rpa    = cnt_a_q - CNT_W'(1) - {1'b0, rd.idx};
		rpb    = cnt_b_q - CNT_W'(1) - {1'b0, rd.idx};
		addr_a = rev_a ? rpa[IDX_W-1:0] : rd.idx;
		addr_b = rev_b ? rpb[IDX_W-1:0] : rd.idx;
	end

	// writes
	always_ff @(posedge clk) begin
		if (wr_a_ok) mem_a[cnt_a_q[IDX_W-1:0]] <= wr_v;
		if (wr_b_ok) mem_b[cnt_b_q[IDX_W-1:0]] <= wr_v;
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (rd.en) begin
			ra_q  <= mem_a[addr_a];
			rb_q  <= mem_b[addr_b];
			sel_q <= rd.poly_b;
		end
	end

	assign rd_v  = sel_q ? rb_q : ra_q;
	assign cnt_a = cnt_a_q;
	assign cnt_b = cnt_b_q;

endmodule

// ===== design/cpmd_mac.sv =====
// shared multiplier: cross or dot product of two difference vectors
module cpmd_mac import cpmd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_req_t req,
	output mac_rsp_t rsp
);

	mph_t ph_q, ph_nxt;
	logic dot_q;
	dvec_t u_q, v_q;
	logic signed [24:0]      mul_a, mul_b;
	logic signed [ACC_W-1:0] prod_c, prod_q, acc_q;
	logic                    done_q;

	// phase sequence
	always_comb begin
		case (ph_q)
			MP_IDLE: ph_nxt = req.start ? MP_MUL1 : MP_IDLE;
			MP_MUL1: ph_nxt = MP_MUL2;
			MP_MUL2: ph_nxt = MP_ACC;
			MP_ACC:  ph_nxt = MP_IDLE;
			default: ph_nxt = MP_IDLE;
		endcase
	end

	// operand select for the one multiplier
	always_comb begin
		mul_a = (ph_q == MP_MUL1) ? u_q.x : u_q.y;
		if (dot_q) mul_b = (ph_q == MP_MUL1) ? v_q.x : v_q.y;
		else       mul_b = (ph_q == MP_MUL1) ? v_q.y : v_q.x;
		prod_c = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= MP_IDLE;
			done_q <= 1'b0;
		end else begin
			ph_q   <= ph_nxt;
			done_q <= (ph_q == MP_ACC);
		end
	end

	// operands, product and accumulator
	always_ff @(posedge clk) begin
		case (ph_q)
			MP_IDLE: begin
				if (req.start) begin
					dot_q <= req.dot;
					u_q   <= req.u;
					v_q   <= req.v;
				end
			end
			MP_MUL1: prod_q <= prod_c;
			MP_MUL2: begin
				acc_q  <= prod_q;
				prod_q <= prod_c;
			end
			MP_ACC:  acc_q <= dot_q ? acc_q + prod_q : acc_q - prod_q;
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.acc  = acc_q;

endmodule

// ===== design/cpmd_rootdiv.sv =====
// bit-serial integer square root and divider sharing one subtract-compare
module cpmd_rootdiv import cpmd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rdv_req_t req,
	output rdv_rsp_t rsp
);

	logic              busy_q, done_q, div_q;
	logic [ITER_W-1:0] n_q;
	logic [ACC_W-1:0]  src_q, res_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIST_W-1:0] den_q;
	logic [REM_W-1:0]  shifted, trial, diff;
	logic              ge;

	// one root digit or one quotient bit per cycle
	always_comb begin
		if (div_q) begin
			shifted = {rem_q[REM_W-2:0], src_q[ACC_W-1]};
			trial   = REM_W'(den_q);
		end else begin
			shifted = {rem_q[REM_W-3:0], src_q[ACC_W-1:ACC_W-2]};
			trial   = {1'b0, res_q[DIST_W-1:0], 2'b01};
		end
		ge   = (shifted >= trial);
		diff = shifted - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && n_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			src_q <= req.src;
			den_q <= req.den;
			rem_q <= '0;
			res_q <= '0;
			n_q   <= req.is_div ? ITER_DIV : ITER_SQRT;
		end else if (busy_q) begin
			rem_q <= ge ? diff : shifted;
			res_q <= {res_q[ACC_W-2:0], ge};
			src_q <= div_q ? {src_q[ACC_W-2:0], 1'b0} : {src_q[ACC_W-3:0], 2'b00};
			n_q   <= n_q - ITER_W'(1);
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule
